// ===== src/tmpg_pkg.sv =====
// Package for the text-mode pixel generator: geometry constants, memory sizes
// and the operation codes. No dependencies.
package tmpg_pkg;

  localparam int TEXT_COLUMNS = 32;
  localparam int TEXT_ROWS    = 12;
  localparam int MARGIN       = 16;

  localparam int GLYPH_W = 4;
  localparam int GLYPH_H = 8;

  localparam int CELL_DEPTH = TEXT_COLUMNS * TEXT_ROWS;
  localparam int FONT_DEPTH = 256;
  localparam int CELL_AW    = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
  localparam int FONT_AW    = $clog2(FONT_DEPTH);

  localparam int CLR_DEPTH = (CELL_DEPTH > FONT_DEPTH) ? CELL_DEPTH : FONT_DEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  localparam int LEFT   = MARGIN;
  localparam int TOP    = MARGIN;
  localparam int RIGHT  = MARGIN + GLYPH_W * TEXT_COLUMNS;
  localparam int BOTTOM = MARGIN + GLYPH_H * TEXT_ROWS;

  // wide enough for any frame edge and any linear cell index
  localparam int COORD_W = 10;
  localparam int IDX_W   = 12;

  localparam int WORD_W  = 16;
  localparam int COLOR_W = 4;

  typedef enum logic [1:0] {
    OP_CELL_WR = 2'd0,
    OP_FONT_WR = 2'd1,
    OP_BORDER  = 2'd2,
    OP_RENDER  = 2'd3
  } tmpg_op_t;

endpackage

// ===== src/tmpg_in_if.sv =====
// Input channel of the text-mode pixel generator: valid/ready and one request.
// Depends on tmpg_pkg.
interface tmpg_in_if
  import tmpg_pkg::*;
;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [8:0]  address;
  logic [15:0] data;
  logic [7:0]  pixel_x;
  logic [6:0]  pixel_y;
  logic        blink_phase;

  modport source (output valid, opcode, address, data, pixel_x, pixel_y, blink_phase,
                  input ready);
  modport sink   (input valid, opcode, address, data, pixel_x, pixel_y, blink_phase,
                  output ready);
endinterface

// ===== src/tmpg_out_if.sv =====
// Result channel of the text-mode pixel generator: valid/ready and a palette index.
// Depends on tmpg_pkg.
interface tmpg_out_if
  import tmpg_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;

  modport source (output valid, pixel_color, input ready);
  modport sink   (input valid, pixel_color, output ready);
endinterface

// ===== src/tmpg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tmpg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/text_mode_pixel_generator_top.sv =====
// Text-mode pixel generator top level: four-stage pipeline over cell and font RAMs.
// Depends on tmpg_pkg, tmpg_in_if, tmpg_out_if and tmpg_ram.
//
//   channel  | dir | payload                                            | transaction
//   in_ch    | in  | opcode address data pixel_x pixel_y blink_phase    | valid & ready
//   out_ch   | out | pixel_color (render requests only)                 | valid & ready
//
// One transaction per cycle sustained while out_ch.ready holds; a render result
// passes from the input register through the cell RAM read, the font RAM read
// and the color select into the output register.
// After reset a clearing pass steps over CLR_DEPTH addresses (384 by default) and
// zeroes both RAMs; in_ch.ready stays low until it ends.
// Each stage advances when the next one is empty or advancing; bubbles collapse.
// Cell writes share the cell read stage, font writes the font read stage and border
// writes the select stage, so every request sees exactly the writes before it.
module text_mode_pixel_generator_top
  import tmpg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  tmpg_in_if.sink   in_ch,
  tmpg_out_if.source out_ch
);

  // clearing pass
  logic [CLR_W-1:0] clr_idx_r;
  logic             clr_done_r;

  // stage 1: input register
  logic               v1_r;
  tmpg_op_t           op1_r;
  logic [8:0]         addr1_r;
  logic [WORD_W-1:0]  data1_r;
  logic [7:0]         px1_r;
  logic [6:0]         py1_r;
  logic               ph1_r;

  // stage 2: cell word available
  logic               v2_r;
  tmpg_op_t           op2_r;
  logic [8:0]         addr2_r;
  logic [WORD_W-1:0]  data2_r;
  logic               area2_r;
  logic [1:0]         cx2_r;
  logic [2:0]         cy2_r;
  logic               ph2_r;
  logic [WORD_W-1:0]  cell_q;

  // stage 3: font word available
  logic               v3_r;
  tmpg_op_t           op3_r;
  logic [COLOR_W-1:0] data3_r;
  logic               area3_r;
  logic [COLOR_W-1:0] fg3_r;
  logic [COLOR_W-1:0] bg3_r;
  logic [3:0]         bit3_r;
  logic [WORD_W-1:0]  font_q;

  logic [COLOR_W-1:0] border_r;
  logic               out_valid_r;
  logic [COLOR_W-1:0] color_r;

  logic rdy_out, rdy3, rdy2, rdy1;
  logic load1, move1, move2, move3, load_out;

  assign rdy_out = !out_valid_r || out_ch.ready;
  assign rdy3    = !v3_r || rdy_out;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;

  assign in_ch.ready = rdy1 && clr_done_r;
  assign load1    = in_ch.valid && in_ch.ready;
  assign move1    = v1_r && rdy2;
  assign move2    = v2_r && rdy3;
  assign move3    = v3_r && rdy_out;
  assign load_out = move3 && (op3_r == OP_RENDER);

  // stage 1 decode
  logic [COORD_W-1:0] px_e, py_e, dx, dy;
  logic               area1;
  logic [IDX_W-1:0]   lin1;
  logic               cell_we;
  logic [CELL_AW-1:0] cell_waddr;
  logic [WORD_W-1:0]  cell_wdata;

  always_comb begin
    px_e  = COORD_W'(px1_r);
    py_e  = COORD_W'(py1_r);
    dx    = px_e - COORD_W'(LEFT);
    dy    = py_e - COORD_W'(TOP);
    area1 = (px_e >= COORD_W'(LEFT)) && (px_e < COORD_W'(RIGHT)) &&
            (py_e >= COORD_W'(TOP)) && (py_e < COORD_W'(BOTTOM));
    lin1  = IDX_W'(dy[COORD_W-1:3]) * IDX_W'(TEXT_COLUMNS) + IDX_W'(dx[COORD_W-1:2]);
  end

  always_comb begin
    if (!clr_done_r) begin
      cell_we    = ({1'b0, clr_idx_r} < (CLR_W + 1)'(CELL_DEPTH));
      cell_waddr = CELL_AW'(clr_idx_r);
      cell_wdata = '0;
    end else begin
      cell_we    = move1 && (op1_r == OP_CELL_WR) &&
                   (IDX_W'(addr1_r) < IDX_W'(CELL_DEPTH));
      cell_waddr = CELL_AW'(addr1_r);
      cell_wdata = data1_r;
    end
  end

  tmpg_ram #(.WIDTH(WORD_W), .DEPTH(CELL_DEPTH)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .re    (move1),
    .raddr (lin1[CELL_AW-1:0]),
    .rdata (cell_q)
  );

  // stage 2 decode
  logic [COLOR_W-1:0] bg2, fg2;
  logic               font_we;
  logic [FONT_AW-1:0] font_waddr;
  logic [WORD_W-1:0]  font_wdata;
  logic [FONT_AW-1:0] font_raddr;

  always_comb begin
    bg2 = cell_q[11:8];
    fg2 = (cell_q[7] && ph2_r) ? bg2 : cell_q[15:12];
    font_raddr = {cell_q[6:0], cx2_r[1]};
  end

  always_comb begin
    if (!clr_done_r) begin
      font_we    = ({1'b0, clr_idx_r} < (CLR_W + 1)'(FONT_DEPTH));
      font_waddr = FONT_AW'(clr_idx_r);
      font_wdata = '0;
    end else begin
      font_we    = move2 && (op2_r == OP_FONT_WR) && (10'(addr2_r) < 10'(FONT_DEPTH));
      font_waddr = addr2_r[FONT_AW-1:0];
      font_wdata = data2_r;
    end
  end

  tmpg_ram #(.WIDTH(WORD_W), .DEPTH(FONT_DEPTH)) u_font_ram (
    .clk   (clk),
    .we    (font_we),
    .waddr (font_waddr),
    .wdata (font_wdata),
    .re    (move2),
    .raddr (font_raddr),
    .rdata (font_q)
  );

  // stage 3 select
  logic [COLOR_W-1:0] color3;

  assign color3 = area3_r ? (font_q[bit3_r] ? fg3_r : bg3_r) : border_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      clr_done_r  <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      border_r    <= '0;
    end else begin
      if (!clr_done_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == CLR_W'(CLR_DEPTH - 1)) begin
          clr_done_r <= 1'b1;
        end
      end
      if (rdy1) begin
        v1_r <= load1;
      end
      if (rdy2) begin
        v2_r <= move1;
      end
      if (rdy3) begin
        v3_r <= move2;
      end
      if (rdy_out) begin
        out_valid_r <= load_out;
      end
      if (move3 && (op3_r == OP_BORDER)) begin
        border_r <= data3_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load1) begin
      op1_r   <= tmpg_op_t'(in_ch.opcode);
      addr1_r <= in_ch.address;
      data1_r <= in_ch.data;
      px1_r   <= in_ch.pixel_x;
      py1_r   <= in_ch.pixel_y;
      ph1_r   <= in_ch.blink_phase;
    end
    if (move1) begin
      op2_r   <= op1_r;
      addr2_r <= addr1_r;
      data2_r <= data1_r;
      area2_r <= area1;
      cx2_r   <= dx[1:0];
      cy2_r   <= dy[2:0];
      ph2_r   <= ph1_r;
    end
    if (move2) begin
      op3_r   <= op2_r;
      data3_r <= data2_r[COLOR_W-1:0];
      area3_r <= area2_r;
      fg3_r   <= fg2;
      bg3_r   <= bg2;
      bit3_r  <= {~cx2_r[0], cy2_r};
    end
    if (load_out) begin
      color_r <= color3;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_color = color_r;

  // no transaction is taken and no stage is busy while the RAMs are cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_done_r |-> !in_ch.ready && !v1_r && !v2_r && !v3_r)
    else $error("pipeline active during clearing pass");

  // a render leaving stage 3 into a free output register shows up next cycle
  a_render_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && (op3_r == OP_RENDER) && rdy_out) |=> out_valid_r)
    else $error("render result lost");

  // after the clearing pass only cell-write transactions write the cell RAM
  a_cell_we_op: assert property (@(posedge clk) disable iff (!rst_n)
    (clr_done_r && cell_we) |-> (v1_r && (op1_r == OP_CELL_WR)))
    else $error("cell RAM written by a non-write transaction");

  // a stalled stage 2 keeps its item
  a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy3) |=> v2_r && $stable(op2_r))
    else $error("stage 2 item dropped during stall");

endmodule

// ===== sim/tmpg_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the text-mode pixel generator: mirrors cell, font and border state
// from accepted requests, predicts render colors and compares results in order.
// Depends on tmpg_pkg, tmpg_in_if and tmpg_out_if.
module tmpg_checker
  import tmpg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  tmpg_in_if   in_ch,
  tmpg_out_if  out_ch,
  output int   fail_count,
  output int   pending
);

  logic [WORD_W-1:0]  cell_mem [CELL_DEPTH];
  logic [WORD_W-1:0]  font_mem [FONT_DEPTH];
  logic [COLOR_W-1:0] border_reg;
  logic [COLOR_W-1:0] color_q [$];
  int errors = 0;
  int n_waiting = 0;

  assign fail_count = errors;
  assign pending    = n_waiting;

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [COLOR_W-1:0] color_at(logic [7:0] px, logic [6:0] py,
                                                  logic phase);
    int dx, dy, cx, cy, bitpos;
    logic [WORD_W-1:0]  cell_w, fword;
    logic [COLOR_W-1:0] bg, fg;
    if (px < LEFT || px >= RIGHT || py < TOP || py >= BOTTOM)
      return border_reg;
    dx = int'(px) - LEFT;
    dy = int'(py) - TOP;
    cx = dx % GLYPH_W;
    cy = dy % GLYPH_H;
    cell_w = cell_mem[(dy / GLYPH_H) * TEXT_COLUMNS + dx / GLYPH_W];
    bg = cell_w[11:8];
    fg = cell_w[15:12];
    // blinking cell in its off phase shows background only
    if (cell_w[7] && phase)
      fg = bg;
    fword = font_mem[(int'(cell_w[6:0]) * 2 + cx / 2) % FONT_DEPTH];
    bitpos = (cx % 2 == 1) ? cy : 8 + cy;
    return fword[bitpos] ? fg : bg;
  endfunction

  always @(posedge clk) begin
    logic [COLOR_W-1:0] want;
    if (!rst_n) begin
      foreach (cell_mem[i]) cell_mem[i] = '0;
      foreach (font_mem[i]) font_mem[i] = '0;
      border_reg = '0;
      color_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (color_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result pixel_color=%0h", out_ch.pixel_color));
        end else begin
          want = color_q.pop_front();
          if (out_ch.pixel_color !== want)
            report_mismatch($sformatf("pixel_color got %0h want %0h",
                                      out_ch.pixel_color, want));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        case (tmpg_op_t'(in_ch.opcode))
          OP_CELL_WR: begin
            if (in_ch.address < CELL_DEPTH)
              cell_mem[in_ch.address] = in_ch.data;
          end
          OP_FONT_WR: begin
            if (in_ch.address < FONT_DEPTH)
              font_mem[in_ch.address] = in_ch.data;
          end
          OP_BORDER: begin
            border_reg = in_ch.data[COLOR_W-1:0];
          end
          default: begin
            color_q.push_back(color_at(in_ch.pixel_x, in_ch.pixel_y, in_ch.blink_phase));
          end
        endcase
      end
    end
    n_waiting <= color_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for text_mode_pixel_generator_top: clock, reset, directed and random
// request streams under varying backpressure; verdict from tmpg_checker.
// Depends on tmpg_pkg, tmpg_in_if, tmpg_out_if, tmpg_checker and the RTL.
module tb_top;
  import tmpg_pkg::*;

  localparam int ITEMS_PER_PHASE = 188;
  localparam int DRAIN_CYCLES    = 20;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   last_cell;
  logic [6:0] last_glyph;

  tmpg_in_if  in_ch ();
  tmpg_out_if out_ch ();

  text_mode_pixel_generator_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tmpg_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("text_mode_pixel_generator_top regression: fail");
    $finish;
  end

  // result side backpressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(tmpg_op_t op, logic [8:0] addr, logic [15:0] data,
                           logic [7:0] px, logic [6:0] py, logic ph);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.address     <= addr;
    in_ch.data        <= data;
    in_ch.pixel_x     <= px;
    in_ch.pixel_y     <= py;
    in_ch.blink_phase <= ph;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // unused fields carry random noise
  task automatic wr_cell(logic [8:0] addr, logic [15:0] data);
    send_item(OP_CELL_WR, addr, data, 8'($urandom), 7'($urandom), 1'($urandom));
  endtask

  task automatic wr_font(logic [8:0] addr, logic [15:0] data);
    send_item(OP_FONT_WR, addr, data, 8'($urandom), 7'($urandom), 1'($urandom));
  endtask

  task automatic set_border(logic [15:0] data);
    send_item(OP_BORDER, 9'($urandom), data, 8'($urandom), 7'($urandom), 1'($urandom));
  endtask

  task automatic render(logic [7:0] px, logic [6:0] py, logic ph);
    send_item(OP_RENDER, 9'($urandom), 16'($urandom), px, py, ph);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(int n);
    int r;
    logic [8:0]  addr;
    logic [15:0] data;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      data = 16'($urandom);
      if (r < 25) begin
        addr = ($urandom_range(9) == 0) ? 9'($urandom_range(511, CELL_DEPTH))
                                        : 9'($urandom_range(CELL_DEPTH - 1));
        if (addr < CELL_DEPTH) begin
          last_cell  = int'(addr);
          last_glyph = data[6:0];
        end
        wr_cell(addr, data);
      end else if (r < 45) begin
        case ($urandom_range(9))
          0:       addr = 9'($urandom_range(511, FONT_DEPTH));
          1, 2, 3: addr = 9'($urandom_range(FONT_DEPTH - 1));
          default: addr = {1'b0, last_glyph, 1'($urandom)};
        endcase
        wr_font(addr, data);
      end else if (r < 50) begin
        set_border(data);
      end else begin
        case ($urandom_range(3))
          0:       render(8'($urandom), 7'($urandom), 1'($urandom));
          1:       render(8'($urandom_range(RIGHT - 1, LEFT)),
                          7'($urandom_range(BOTTOM - 1, TOP)), 1'($urandom));
          default: render(8'(LEFT + (last_cell % TEXT_COLUMNS) * GLYPH_W +
                             $urandom_range(GLYPH_W - 1)),
                          7'(TOP + (last_cell / TEXT_COLUMNS) * GLYPH_H +
                             $urandom_range(GLYPH_H - 1)),
                          1'($urandom));
        endcase
      end
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.opcode      <= OP_CELL_WR;
    in_ch.address     <= '0;
    in_ch.data        <= '0;
    in_ch.pixel_x     <= '0;
    in_ch.pixel_y     <= '0;
    in_ch.blink_phase <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    last_cell      = 0;
    last_glyph     = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // cleared state, border and frame edges
    render(8'd0, 7'd0, 1'b0);
    render(8'(LEFT), 7'(TOP), 1'b1);
    set_border(16'hFFF7);
    render(8'(LEFT - 1), 7'(TOP), 1'b0);
    render(8'(LEFT), 7'(TOP - 1), 1'b0);
    render(8'(RIGHT), 7'(BOTTOM - 1), 1'b1);
    render(8'(RIGHT - 1), 7'(BOTTOM), 1'b0);
    render(8'd255, 7'd127, 1'b1);
    // font and cell stores, including ignored out-of-range writes
    wr_font(9'd0, 16'hA5C3);
    wr_font(9'd1, 16'h5A3C);
    wr_font(9'd255, 16'hFFFF);
    wr_font(9'd256, 16'hFFFF);
    wr_font(9'd511, 16'h1234);
    wr_cell(9'd0, 16'hF100);
    wr_cell(9'(CELL_DEPTH - 1), 16'h2CFF);
    wr_cell(9'(CELL_DEPTH), 16'hFFFF);
    wr_cell(9'd511, 16'h0000);
    for (int x = 0; x < GLYPH_W; x++) render(8'(LEFT + x), 7'(TOP + x), 1'b0);
    render(8'(RIGHT - 1), 7'(BOTTOM - 1), 1'b0);
    render(8'(RIGHT - 1), 7'(BOTTOM - 1), 1'b1);
    // font writes replace the whole word
    wr_font(9'd0, 16'h0000);
    render(8'(LEFT), 7'(TOP + 7), 1'b0);
    wait_drained();

    send_idle_pct = 0;  recv_stall_pct = 0;  run_random(ITEMS_PER_PHASE);
    wait_drained();
    send_idle_pct = 88; recv_stall_pct = 0;  run_random(ITEMS_PER_PHASE);
    wait_drained();
    send_idle_pct = 0;  recv_stall_pct = 88; run_random(ITEMS_PER_PHASE);
    wait_drained();
    send_idle_pct = 38; recv_stall_pct = 38; run_random(ITEMS_PER_PHASE);
    wait_drained();

    if (fail_count == 0 && pending == 0)
      $display("text_mode_pixel_generator_top regression: pass");
    else
      $display("text_mode_pixel_generator_top regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
src/tmpg_pkg.sv
src/tmpg_in_if.sv
src/tmpg_out_if.sv
src/tmpg_ram.sv
src/text_mode_pixel_generator_top.sv
sim/tmpg_checker.sv
sim/tb_top.sv
